// ===== rtl/catmull_rom_spline_eval_top_defines.svh =====
// Assertion macros for the spline evaluator RTL.
`ifndef CATMULL_ROM_SPLINE_EVAL_TOP_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVAL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define CRSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define CRSE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRSE_ASSERT(lbl, prop, msg)
`define CRSE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/crse_pkg.sv =====
`timescale 1ns / 1ps
package crse_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned TimeW    = 17;
  localparam int unsigned FracW    = 16;
  localparam int unsigned HornW    = 40;
  localparam int unsigned ProdW    = HornW + FracW + 1;
  localparam int unsigned NumPtsW  = 7;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // Word select bit of paddr for the num_points register.
  localparam logic REG_NUM_POINTS = 1'b0;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ADD_C2,
    ADD_C1,
    ADD_C0
  } add_sel_t;

  typedef struct packed {
    logic       take;
    logic       seg_calc;
    logic       rd_en;
    logic [1:0] rd_idx;
    logic       shift_p;
    logic       coef_ld;
    logic       mul;
    logic       add;
    add_sel_t   add_sel;
    logic       out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic quick;
  } dp_stat_t;

endpackage

// ===== rtl/crse_lane.sv =====
`timescale 1ns / 1ps
module crse_lane (
  input  logic                                clk,
  input  logic signed [crse_pkg::CoordW-1:0]  p0_i,
  input  logic signed [crse_pkg::CoordW-1:0]  p1_i,
  input  logic signed [crse_pkg::CoordW-1:0]  p2_i,
  input  logic signed [crse_pkg::CoordW-1:0]  p3_i,
  input  logic        [crse_pkg::FracW-1:0]   u_i,
  input  crse_pkg::dp_cmd_t                   cmd_i,
  output logic signed [crse_pkg::CoordW-1:0]  res_o
);
  import crse_pkg::*;

  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(1) << (FracW - 1);
  localparam int unsigned TopW = HornW - CoordW + 1;

  logic signed [HornW-1:0] e0, e1, e2, e3, d12;
  logic signed [HornW-1:0] c3, c2, c1, c0;
  logic signed [HornW-1:0] c2_r, c1_r, c0_r, h_r, h_nxt;
  logic signed [HornW-1:0] c_sel, rnd, fin;
  logic signed [ProdW-1:0] prod_r, prod_rnd;
  logic        [TopW-1:0]  top_bits;
  logic                    ovf;

  always_comb begin
    e0  = HornW'(p0_i);
    e1  = HornW'(p1_i);
    e2  = HornW'(p2_i);
    e3  = HornW'(p3_i);
    d12 = e1 - e2;
    c3  = d12 + (d12 <<< 1) + e3 - e0;
    c2  = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    c1  = e2 - e0;
    c0  = e1 <<< 1;
  end

  // Round the Q16 product to nearest, ties toward plus infinity.
  assign prod_rnd = prod_r + RoundHalf;
  assign rnd      = HornW'(prod_rnd >>> FracW);

  always_comb begin
    case (cmd_i.add_sel)
      ADD_C2:  c_sel = c2_r;
      ADD_C1:  c_sel = c1_r;
      ADD_C0:  c_sel = c0_r;
      default: c_sel = c0_r;
    endcase
  end

  always_comb begin
    h_nxt = h_r;
    if (cmd_i.coef_ld) begin
      h_nxt = c3;
    end else if (cmd_i.add) begin
      h_nxt = c_sel + rnd;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    if (cmd_i.coef_ld) begin
      c2_r <= c2;
      c1_r <= c1;
      c0_r <= c0;
    end
    if (cmd_i.mul) begin
      prod_r <= h_r * $signed({1'b0, u_i});
    end
  end

  // Halve with rounding, then clamp to 32 bits.
  assign fin      = (h_r + $signed(HornW'(1))) >>> 1;
  assign top_bits = fin[HornW-1:CoordW-1];
  assign ovf      = (|top_bits) && !(&top_bits);

  always_comb begin
    if (ovf) begin
      res_o = fin[HornW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      res_o = $signed(fin[CoordW-1:0]);
    end
  end

endmodule

// ===== rtl/crse_dp.sv =====
`timescale 1ns / 1ps
module crse_dp #(
  parameter int MAX_POINTS = 64
) (
  input  logic                                clk,
  input  logic                                in_kind,
  input  logic        [crse_pkg::IdxW-1:0]    in_point_index,
  input  logic signed [crse_pkg::CoordW-1:0]  in_point_x,
  input  logic signed [crse_pkg::CoordW-1:0]  in_point_y,
  input  logic        [crse_pkg::TimeW-1:0]   in_eval_time,
  input  logic        [crse_pkg::NumPtsW-1:0] num_points,
  input  crse_pkg::dp_cmd_t                   cmd_i,
  output crse_pkg::dp_stat_t                  stat_o,
  output logic signed [crse_pkg::CoordW-1:0]  out_curve_x,
  output logic signed [crse_pkg::CoordW-1:0]  out_curve_y,
  output logic                                out_in_range
);
  import crse_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = (NW > NumPtsW) ? NW : NumPtsW;
  localparam int SW = NW + 1;
  localparam int EW = 2 * CoordW;

  logic [EW-1:0]       mem [MAX_POINTS];
  logic [EW-1:0]       rdata_r, pa_r, pb_r, pc_r;
  logic [CW-1:0]       np_ext, idx_ext;
  logic [NW-1:0]       n_eff, nm3, seg_raw, seg_sel;
  logic [FracW+NW-1:0] scaled_r;
  logic [FracW-1:0]    u_r;
  logic [AW-1:0]       seg_r, rd_addr, wr_addr;
  logic                quick_r, idx_ok, wr_en;
  logic signed [CoordW-1:0] res_x, res_y;

  // Point counts above the store depth act as the depth.
  assign np_ext  = CW'(num_points);
  assign n_eff   = (np_ext > CW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(np_ext);
  assign nm3     = n_eff - NW'(3);

  assign idx_ext = CW'(in_point_index);
  assign idx_ok  = idx_ext < CW'(MAX_POINTS);
  assign wr_addr = AW'(idx_ext);
  assign wr_en   = cmd_i.take && (in_kind == KIND_LOAD) && idx_ok;

  // A segment index past the last full segment is pulled back to it.
  assign seg_raw = scaled_r[FracW+NW-1:FracW];
  assign seg_sel = ({1'b0, seg_raw} + SW'(3) >= {1'b0, n_eff}) ? (n_eff - NW'(4)) : seg_raw;
  assign rd_addr = seg_r + AW'(cmd_i.rd_idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_point_x, in_point_y};
    end
    if (cmd_i.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.take) begin
      scaled_r <= in_eval_time[FracW-1:0] * nm3;
      quick_r  <= (n_eff < NW'(4)) || in_eval_time[TimeW-1];
    end
    if (cmd_i.seg_calc) begin
      seg_r <= AW'(seg_sel);
      u_r   <= scaled_r[FracW-1:0];
    end
    if (cmd_i.shift_p) begin
      pa_r <= pb_r;
      pb_r <= pc_r;
      pc_r <= rdata_r;
    end
    if (cmd_i.out_ld) begin
      if (quick_r) begin
        out_curve_x  <= '0;
        out_curve_y  <= '0;
        out_in_range <= 1'b0;
      end else begin
        out_curve_x  <= res_x;
        out_curve_y  <= res_y;
        out_in_range <= 1'b1;
      end
    end
  end

  assign stat_o.quick = quick_r;

  crse_lane u_lane_x (
    .clk   (clk),
    .p0_i  ($signed(pa_r[EW-1:CoordW])),
    .p1_i  ($signed(pb_r[EW-1:CoordW])),
    .p2_i  ($signed(pc_r[EW-1:CoordW])),
    .p3_i  ($signed(rdata_r[EW-1:CoordW])),
    .u_i   (u_r),
    .cmd_i (cmd_i),
    .res_o (res_x)
  );

  crse_lane u_lane_y (
    .clk   (clk),
    .p0_i  ($signed(pa_r[CoordW-1:0])),
    .p1_i  ($signed(pb_r[CoordW-1:0])),
    .p2_i  ($signed(pc_r[CoordW-1:0])),
    .p3_i  ($signed(rdata_r[CoordW-1:0])),
    .u_i   (u_r),
    .cmd_i (cmd_i),
    .res_o (res_y)
  );

endmodule

// ===== rtl/crse_ctrl.sv =====
`timescale 1ns / 1ps
`include "catmull_rom_spline_eval_top_defines.svh"
module crse_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_stall,
  input  logic               out_stall,
  output logic               out_valid,
  input  crse_pkg::dp_stat_t stat_i,
  output crse_pkg::dp_cmd_t  cmd_o
);
  import crse_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_COEF,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd_o          = '0;
    cmd_o.add_sel  = ADD_C0;
    cmd_o.take     = in_valid && (state_r == ST_IDLE);
    cmd_o.seg_calc = (state_r == ST_SEG);
    cmd_o.coef_ld  = (state_r == ST_COEF);
    cmd_o.mul      = (state_r == ST_MUL);
    cmd_o.add      = (state_r == ST_ADD);
    cmd_o.out_ld   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
    case (state_r)
      ST_RD0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_idx = 2'd0;
      end
      ST_RD1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_idx  = 2'd1;
        cmd_o.shift_p = 1'b1;
      end
      ST_RD2: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_idx  = 2'd2;
        cmd_o.shift_p = 1'b1;
      end
      ST_RD3: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_idx  = 2'd3;
        cmd_o.shift_p = 1'b1;
      end
      default: begin
      end
    endcase
    case (cnt_r)
      2'd0:    cmd_o.add_sel = ADD_C2;
      2'd1:    cmd_o.add_sel = ADD_C1;
      default: cmd_o.add_sel = ADD_C0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = 2'd0;
        if (in_valid && (in_kind == KIND_EVAL)) begin
          state_nxt = ST_SEG;
        end
      end
      ST_SEG:  state_nxt = stat_i.quick ? ST_FIN : ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_RD3;
      ST_RD3:  state_nxt = ST_COEF;
      ST_COEF: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD: begin
        cnt_nxt   = cnt_r + 2'd1;
        state_nxt = (cnt_r == 2'd2) ? ST_FIN : ST_MUL;
      end
      ST_FIN: begin
        if (cmd_o.out_ld) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the result word until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_o.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `CRSE_ASSERT(a_fin_gives_word, (state_r == ST_FIN) && (!out_valid_r || !out_stall) |=> out_valid_r, "finished result not presented")
  `CRSE_ASSERT(a_eval_starts, in_valid && (state_r == ST_IDLE) && (in_kind == KIND_EVAL) |=> state_r == ST_SEG, "evaluate word did not start")
  `CRSE_ASSERT(a_coef_after_reads, (state_r == ST_COEF) |-> $past(state_r) == ST_RD3, "coefficients formed before all points read")
  `CRSE_ASSERT_RST(a_reset_clears, !rst_n |=> (state_r == ST_IDLE) && !out_valid_r, "reset did not clear control")

endmodule

// ===== rtl/catmull_rom_spline_eval_top.sv =====
`timescale 1ns / 1ps
// Uniform Catmull-Rom spline evaluator over a store of 2-D control points.
// Input channel (in_valid / in_stall): a load word (in_kind = 0) writes
// in_point_x / in_point_y at in_point_index and gives no result. An evaluate
// word (in_kind = 1) takes t in Q1.16 and gives one result word (out_curve_x,
// out_curve_y, out_in_range) on the output channel. Its steps: scale t, pick
// the segment, four reads of the point memory, form the coefficients, three
// multiply/add rounds of the Horner loop, then round and saturate. With fewer
// than four points or t >= 1.0 it skips from the segment step to the last one
// and returns zeros with out_in_range low.
// in_stall is high while an evaluate word is in flight. A result word waits
// in the output register under out_stall; load words are still taken then,
// and a later evaluate word holds in its last step until the register frees.
// num_points is written over the APB port at address 0 while idle; this is a
// rule for the user, and the block does not enforce it. Reset (rst_n low,
// synchronous) clears num_points and all control state; the point memory is
// not cleared and must be loaded before it is used.
module catmull_rom_spline_eval_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [crse_pkg::CfgAddrW-1:0] paddr,
  input  logic        [crse_pkg::CfgDataW-1:0] pwdata,
  output logic        [crse_pkg::CfgDataW-1:0] prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_kind,
  input  logic        [crse_pkg::IdxW-1:0]     in_point_index,
  input  logic signed [crse_pkg::CoordW-1:0]   in_point_x,
  input  logic signed [crse_pkg::CoordW-1:0]   in_point_y,
  input  logic        [crse_pkg::TimeW-1:0]    in_eval_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [crse_pkg::CoordW-1:0]   out_curve_x,
  output logic signed [crse_pkg::CoordW-1:0]   out_curve_y,
  output logic                                 out_in_range
);
  import crse_pkg::*;

  logic [NumPtsW-1:0] num_points_r, num_points_nxt;
  logic               reg_sel;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  assign reg_sel = (paddr[CfgAddrW-1] == REG_NUM_POINTS);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? CfgDataW'(num_points_r) : '0;

  always_comb begin
    num_points_nxt = num_points_r;
    if (psel && penable && pwrite && reg_sel) begin
      num_points_nxt = pwdata[NumPtsW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= '0;
    end else begin
      num_points_r <= num_points_nxt;
    end
  end

  crse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  crse_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk            (clk),
    .in_kind        (in_kind),
    .in_point_index (in_point_index),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_eval_time   (in_eval_time),
    .num_points     (num_points_r),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_curve_x    (out_curve_x),
    .out_curve_y    (out_curve_y),
    .out_in_range   (out_in_range)
  );

endmodule
